/* src/lcrw_pkg.sv */
// ----------------------------------------------------------------------------
// lcrw_pkg: shared definitions for the rectangular-window line clipper
// Region outcode bits, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package lcrw_pkg;

  typedef logic [3:0] outcode_t;

  localparam outcode_t CODE_INSIDE = 4'd0;
  localparam outcode_t CODE_LEFT   = 4'd1;
  localparam outcode_t CODE_RIGHT  = 4'd2;
  localparam outcode_t CODE_BOTTOM = 4'd4;
  localparam outcode_t CODE_TOP    = 4'd8;

  typedef logic [1:0] reg_idx_t;

  localparam reg_idx_t REG_WINDOW_LEFT   = 2'd0;
  localparam reg_idx_t REG_WINDOW_BOTTOM = 2'd1;
  localparam reg_idx_t REG_WINDOW_RIGHT  = 2'd2;
  localparam reg_idx_t REG_WINDOW_TOP    = 2'd3;

  localparam int WINDOW_LEFT_RST   = 200;
  localparam int WINDOW_BOTTOM_RST = 200;
  localparam int WINDOW_RIGHT_RST  = 400;
  localparam int WINDOW_TOP_RST    = 400;

  typedef logic [2:0] round_t;

  localparam round_t MAX_ROUNDS = 3'd4;

endpackage

`default_nettype wire

/* src/lcrw_channels.sv */
// ----------------------------------------------------------------------------
// lcrw channels: valid/ready interfaces for segments and clipped results
// The segment channel carries two endpoints; the result channel carries the
// accept flag and the clipped endpoints.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcrw_seg_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] start_x;
  logic signed [COORD_BITS-1:0] start_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                output ready);
endinterface

interface lcrw_clip_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic signed [COORD_BITS-1:0] clip_start_x;
  logic signed [COORD_BITS-1:0] clip_start_y;
  logic signed [COORD_BITS-1:0] clip_end_x;
  logic signed [COORD_BITS-1:0] clip_end_y;

  modport source (output valid, output accepted, output clip_start_x, output clip_start_y,
                  output clip_end_x, output clip_end_y, input ready);
  modport sink (input valid, input accepted, input clip_start_x, input clip_start_y,
                input clip_end_x, input clip_end_y, output ready);
endinterface

`default_nettype wire

/* src/line_clipper_rect_window.sv */
// ----------------------------------------------------------------------------
// line_clipper_rect_window: Cohen-Sutherland clipping of a segment to a window
// Clips one segment per transfer against a window held in four registers.
// ----------------------------------------------------------------------------
// Usage:
// A segment arrives on seg_i as two signed integer endpoints. The block takes
// one segment at a time; seg_i.ready is high only while it waits for work.
// Endpoints are held in signed fixed point with FRAC_BITS fraction bits. Each
// clip round moves one outside endpoint to a window edge through the serial
// multiply/divide unit, and there are at most four rounds per segment.
// The result sits in an output register on clip_o until transferred; a new
// segment may be taken while it waits. If the receiver stalls, a finished
// result holds inside the block until the output register is free.
// The user must write the window registers (cfg_we_i/cfg_idx_i/cfg_data_i)
// only while the block is idle; the block itself does not enforce it.
// Reset sets left/bottom to 200 and right/top to 400 and empties the block.
// ----------------------------------------------------------------------------
`default_nettype none

module line_clipper_rect_window #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  lcrw_seg_if.sink                seg_i,
  lcrw_clip_if.source             clip_o,
  input  logic                    cfg_we_i,
  input  lcrw_pkg::reg_idx_t      cfg_idx_i,
  input  logic [COORD_BITS-1:0]   cfg_data_i
);

  localparam int QW = COORD_BITS + FRAC_BITS;
  localparam int DW = QW + 1;

  localparam logic signed [DW-1:0] FRAC_MASK = (DW'(1) << FRAC_BITS) - DW'(1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic signed [COORD_BITS-1:0] left_q, bottom_q, right_q, top_q;
  logic signed [QW-1:0]         left_w, bottom_w, right_w, top_w;

  logic [1:0]                   state_q, state_d;
  logic signed [QW-1:0]         x1_q, x1_d, y1_q, y1_d, x2_q, x2_d, y2_q, y2_d;
  logic signed [QW-1:0]         edge_q, edge_d, base_q, base_d;
  logic                         yedge_q, yedge_d, first_q, first_d;
  logic                         ok_q, ok_d;
  lcrw_pkg::round_t             round_q, round_d;

  logic                         out_valid_q, out_valid_d;
  logic                         out_acc_q, out_acc_d;
  logic signed [COORD_BITS-1:0] out_sx_q, out_sx_d, out_sy_q, out_sy_d;
  logic signed [COORD_BITS-1:0] out_ex_q, out_ex_d, out_ey_q, out_ey_d;

  lcrw_pkg::outcode_t           c1, c2, co;
  logic                         co_yedge;
  logic signed [QW-1:0]         co_edge;
  logic signed [DW-1:0]         dx, dy, md_a, md_b, md_d;
  logic signed [DW-1:0]         moved;
  logic                         md_start, md_done;
  logic signed [DW-1:0]         md_quot;

  function automatic logic signed [QW-1:0] to_q(input logic signed [COORD_BITS-1:0] v);
    return QW'(v) <<< FRAC_BITS;
  endfunction

  function automatic logic [COORD_BITS-1:0] to_int(input logic signed [QW-1:0] v);
    logic signed [DW-1:0] adj;
    adj = DW'(v) + (v[QW-1] ? FRAC_MASK : '0);
    return adj[FRAC_BITS +: COORD_BITS];
  endfunction

  function automatic lcrw_pkg::outcode_t region(
    input logic signed [QW-1:0] x,
    input logic signed [QW-1:0] y,
    input logic signed [QW-1:0] xl,
    input logic signed [QW-1:0] yb,
    input logic signed [QW-1:0] xr,
    input logic signed [QW-1:0] yt
  );
    lcrw_pkg::outcode_t c;
    c = lcrw_pkg::CODE_INSIDE;
    if (x < xl) begin
      c = c | lcrw_pkg::CODE_LEFT;
    end else if (x > xr) begin
      c = c | lcrw_pkg::CODE_RIGHT;
    end
    if (y < yb) begin
      c = c | lcrw_pkg::CODE_BOTTOM;
    end else if (y > yt) begin
      c = c | lcrw_pkg::CODE_TOP;
    end
    return c;
  endfunction

  assign left_w   = to_q(left_q);
  assign bottom_w = to_q(bottom_q);
  assign right_w  = to_q(right_q);
  assign top_w    = to_q(top_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= COORD_BITS'(lcrw_pkg::WINDOW_LEFT_RST);
      bottom_q <= COORD_BITS'(lcrw_pkg::WINDOW_BOTTOM_RST);
      right_q  <= COORD_BITS'(lcrw_pkg::WINDOW_RIGHT_RST);
      top_q    <= COORD_BITS'(lcrw_pkg::WINDOW_TOP_RST);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lcrw_pkg::REG_WINDOW_LEFT:   left_q   <= cfg_data_i;
        lcrw_pkg::REG_WINDOW_BOTTOM: bottom_q <= cfg_data_i;
        lcrw_pkg::REG_WINDOW_RIGHT:  right_q  <= cfg_data_i;
        lcrw_pkg::REG_WINDOW_TOP:    top_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    c1 = region(x1_q, y1_q, left_w, bottom_w, right_w, top_w);
    c2 = region(x2_q, y2_q, left_w, bottom_w, right_w, top_w);
    co = (c1 != lcrw_pkg::CODE_INSIDE) ? c1 : c2;
    co_yedge = |(co & (lcrw_pkg::CODE_TOP | lcrw_pkg::CODE_BOTTOM));
    if (|(co & lcrw_pkg::CODE_TOP)) begin
      co_edge = top_w;
    end else if (|(co & lcrw_pkg::CODE_BOTTOM)) begin
      co_edge = bottom_w;
    end else if (|(co & lcrw_pkg::CODE_RIGHT)) begin
      co_edge = right_w;
    end else begin
      co_edge = left_w;
    end
    dx = DW'(x2_q) - DW'(x1_q);
    dy = DW'(y2_q) - DW'(y1_q);
    if (co_yedge) begin
      md_a = dx;
      md_b = DW'(co_edge) - DW'(y1_q);
      md_d = dy;
    end else begin
      md_a = dy;
      md_b = DW'(co_edge) - DW'(x1_q);
      md_d = dx;
    end
  end

  assign moved = DW'(base_q) + md_quot;

  lcrw_muldiv #(
    .W (QW)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (md_start),
    .a_i     (md_a),
    .b_i     (md_b),
    .d_i     (md_d),
    .done_o  (md_done),
    .quot_o  (md_quot)
  );

  always_comb begin
    state_d     = state_q;
    x1_d        = x1_q;
    y1_d        = y1_q;
    x2_d        = x2_q;
    y2_d        = y2_q;
    edge_d      = edge_q;
    base_d      = base_q;
    yedge_d     = yedge_q;
    first_d     = first_q;
    ok_d        = ok_q;
    round_d     = round_q;
    out_valid_d = out_valid_q;
    out_acc_d   = out_acc_q;
    out_sx_d    = out_sx_q;
    out_sy_d    = out_sy_q;
    out_ex_d    = out_ex_q;
    out_ey_d    = out_ey_q;
    md_start    = 1'b0;

    if (out_valid_q && clip_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (seg_i.valid) begin
          x1_d    = to_q(seg_i.start_x);
          y1_d    = to_q(seg_i.start_y);
          x2_d    = to_q(seg_i.end_x);
          y2_d    = to_q(seg_i.end_y);
          round_d = '0;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (c1 == lcrw_pkg::CODE_INSIDE && c2 == lcrw_pkg::CODE_INSIDE) begin
          ok_d    = 1'b1;
          state_d = ST_DONE;
        end else if ((c1 & c2) != lcrw_pkg::CODE_INSIDE || round_q == lcrw_pkg::MAX_ROUNDS) begin
          ok_d    = 1'b0;
          state_d = ST_DONE;
        end else begin
          md_start = 1'b1;
          edge_d   = co_edge;
          yedge_d  = co_yedge;
          first_d  = (c1 != lcrw_pkg::CODE_INSIDE);
          base_d   = co_yedge ? x1_q : y1_q;
          state_d  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (md_done) begin
          if (first_q) begin
            if (yedge_q) begin
              y1_d = edge_q;
              x1_d = moved[QW-1:0];
            end else begin
              x1_d = edge_q;
              y1_d = moved[QW-1:0];
            end
          end else begin
            if (yedge_q) begin
              y2_d = edge_q;
              x2_d = moved[QW-1:0];
            end else begin
              x2_d = edge_q;
              y2_d = moved[QW-1:0];
            end
          end
          round_d = round_q + 1'b1;
          state_d = ST_EVAL;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || clip_o.ready) begin
          out_valid_d = 1'b1;
          out_acc_d   = ok_q;
          out_sx_d    = ok_q ? to_int(x1_q) : '0;
          out_sy_d    = ok_q ? to_int(y1_q) : '0;
          out_ex_d    = ok_q ? to_int(x2_q) : '0;
          out_ey_d    = ok_q ? to_int(y2_q) : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      round_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      round_q     <= round_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q      <= x1_d;
    y1_q      <= y1_d;
    x2_q      <= x2_d;
    y2_q      <= y2_d;
    edge_q    <= edge_d;
    base_q    <= base_d;
    yedge_q   <= yedge_d;
    first_q   <= first_d;
    ok_q      <= ok_d;
    out_acc_q <= out_acc_d;
    out_sx_q  <= out_sx_d;
    out_sy_q  <= out_sy_d;
    out_ex_q  <= out_ex_d;
    out_ey_q  <= out_ey_d;
  end

  assign seg_i.ready         = (state_q == ST_IDLE);
  assign clip_o.valid        = out_valid_q;
  assign clip_o.accepted     = out_acc_q;
  assign clip_o.clip_start_x = out_sx_q;
  assign clip_o.clip_start_y = out_sy_q;
  assign clip_o.clip_end_x   = out_ex_q;
  assign clip_o.clip_end_y   = out_ey_q;

endmodule

`default_nettype wire

/* src/lcrw_muldiv.sv */
// ----------------------------------------------------------------------------
// lcrw_muldiv: serial signed multiply-then-divide, trunc(a * b / d)
// One shared adder/subtractor does a shift-add multiply and then a restoring
// divide on sign-magnitude operands.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrw_muldiv #(
  parameter int W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic signed [W:0] a_i,
  input  logic signed [W:0] b_i,
  input  logic signed [W:0] d_i,
  output logic              done_o,
  output logic signed [W:0] quot_o
);

  localparam int CNT_W = $clog2(W);

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_MUL  = 2'd1;
  localparam logic [1:0] MD_DIV  = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [W-1:0]     hi_q, hi_d;
  logic [W-1:0]     lo_q, lo_d;
  logic [W-1:0]     mcand_q, mcand_d;
  logic [W-1:0]     dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic             done_q, done_d;

  logic             is_mul;
  logic [W:0]       op_a;
  logic [W:0]       op_b;
  logic [W+1:0]     sum;
  logic             ge;

  function automatic logic [W-1:0] mag(input logic signed [W:0] v);
    logic signed [W:0] t;
    t = v[W] ? -v : v;
    return t[W-1:0];
  endfunction

  assign is_mul = (phase_q == MD_MUL);
  assign op_a   = is_mul ? {1'b0, hi_q} : {hi_q, lo_q[W-1]};
  assign op_b   = is_mul ? (lo_q[0] ? {1'b0, mcand_q} : '0) : {1'b0, dvs_q};
  assign sum    = {1'b0, op_a} + ({1'b0, op_b} ^ {(W+2){!is_mul}}) + (W+2)'(!is_mul);
  assign ge     = !sum[W+1];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    mcand_d = mcand_q;
    dvs_d   = dvs_q;
    neg_d   = neg_q;
    done_d  = 1'b0;
    case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          mcand_d = mag(a_i);
          lo_d    = mag(b_i);
          dvs_d   = mag(d_i);
          hi_d    = '0;
          neg_d   = a_i[W] ^ b_i[W] ^ d_i[W];
          cnt_d   = CNT_W'(W - 1);
          phase_d = MD_MUL;
        end
      end
      MD_MUL: begin
        hi_d = sum[W:1];
        lo_d = {sum[0], lo_q[W-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          cnt_d   = CNT_W'(W - 1);
          phase_d = MD_DIV;
        end
      end
      MD_DIV: begin
        hi_d  = ge ? sum[W-1:0] : op_a[W-1:0];
        lo_d  = {lo_q[W-2:0], ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_d = MD_IDLE;
          done_d  = 1'b1;
        end
      end
      default: begin
        phase_d = MD_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q    <= hi_d;
    lo_q    <= lo_d;
    mcand_q <= mcand_d;
    dvs_q   <= dvs_d;
    neg_q   <= neg_d;
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});

endmodule

`default_nettype wire

/* src/lcrw_checker.sv */
// ----------------------------------------------------------------------------
// lcrw_checker: port-level checks for the rectangular-window line clipper
// Watches the segment and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrw_checker #(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  out_accepted_i,
  input  logic [COORD_BITS-1:0] out_start_x_i,
  input  logic [COORD_BITS-1:0] out_start_y_i,
  input  logic [COORD_BITS-1:0] out_end_x_i,
  input  logic [COORD_BITS-1:0] out_end_y_i
);

  // A pending result must stay offered until the receiver takes it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  // A rejected segment reports all-zero endpoints.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_accepted_i |->
      out_start_x_i == '0 && out_start_y_i == '0 && out_end_x_i == '0 && out_end_y_i == '0)
    else $error("rejected segment carries nonzero endpoints");

  // After a segment transfer the block is busy clipping it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new segment taken while one is in progress");

endmodule

bind line_clipper_rect_window lcrw_checker #(
  .COORD_BITS (COORD_BITS)
) u_lcrw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (seg_i.valid),
  .in_ready_i     (seg_i.ready),
  .out_valid_i    (clip_o.valid),
  .out_ready_i    (clip_o.ready),
  .out_accepted_i (clip_o.accepted),
  .out_start_x_i  (clip_o.clip_start_x),
  .out_start_y_i  (clip_o.clip_start_y),
  .out_end_x_i    (clip_o.clip_end_x),
  .out_end_y_i    (clip_o.clip_end_y)
);

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the rectangular-window line clipper
// Drives segments over the valid/ready channel and checks each result against
// its table entry or a cycle-free outcode clipping predictor. A short table of
// edge cases comes first, then random segments under a series of windows:
// default, random, inverted, full range, single point and tight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

  localparam int     FRAC    = 16;
  localparam int     PHASES  = 8;
  localparam int     PER_PHASE = 62;
  localparam logic [127:0] QUO_SAT = 128'h7fff_ffff_ffff_ffff;

  typedef logic signed [15:0] coord_t;

  typedef struct {
    coord_t sx;
    coord_t sy;
    coord_t ex;
    coord_t ey;
  } seg_t;

  typedef struct {
    logic   acc;
    coord_t csx;
    coord_t csy;
    coord_t cex;
    coord_t cey;
  } clip_t;

  typedef struct {
    bit win;
    int wl, wb, wr, wt;
    int sx, sy, ex, ey;
    bit typed;
    bit acc;
    int csx, csy, cex, cey;
  } probe_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  lcrw_pkg::reg_idx_t cfg_idx_i;
  logic [15:0]        cfg_data_i;

  lcrw_seg_if  #(.COORD_BITS(16)) seg_link ();
  lcrw_clip_if #(.COORD_BITS(16)) clip_link ();

  line_clipper_rect_window dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seg_i      (seg_link),
    .clip_o     (clip_link),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  coord_t win_l = coord_t'(lcrw_pkg::WINDOW_LEFT_RST);
  coord_t win_b = coord_t'(lcrw_pkg::WINDOW_BOTTOM_RST);
  coord_t win_r = coord_t'(lcrw_pkg::WINDOW_RIGHT_RST);
  coord_t win_t = coord_t'(lcrw_pkg::WINDOW_TOP_RST);

  clip_t pending_clips[$];
  int    mismatch_count = 0;
  bit    idle_on = 1'b1;
  int    stall_left = 0;

  probe_t probes[23] = '{
    '{0, 0, 0, 0, 0,   250, 250, 350, 350,  1, 1, 250, 250, 350, 350},
    '{0, 0, 0, 0, 0,   200, 200, 400, 400,  1, 1, 200, 200, 400, 400},
    '{0, 0, 0, 0, 0,   300, 300, 300, 300,  1, 1, 300, 300, 300, 300},
    '{0, 0, 0, 0, 0,     0, 300, 100, 300,  1, 0,   0,   0,   0,   0},
    '{0, 0, 0, 0, 0,   300, 500, 350, 32767, 1, 0,  0,   0,   0,   0},
    '{0, 0, 0, 0, 0,   100, 300, 500, 300,  1, 1, 200, 300, 400, 300},
    '{0, 0, 0, 0, 0,   300,   0, 300, 600,  1, 1, 300, 200, 300, 400},
    '{0, 0, 0, 0, 0, -32768, -32768, -32768, -32768, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0,  32767,  32767,  32767,  32767, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, -32768, -32768,  32767,  32767, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0,  32767, -32768, -32768,  32767, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0,     0, 350, 250, 600,  0, 0,   0,   0,   0,   0},
    '{0, 0, 0, 0, 0,   150, 100, 450, 500,  0, 0,   0,   0,   0,   0},
    '{0, 0, 0, 0, 0,   500, 300, 300, 300,  1, 1, 400, 300, 300, 300},
    '{0, 0, 0, 0, 0,   300, 250, 300, -100, 1, 1, 300, 250, 300, 200},
    '{1, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768,
        1, 1, -32768, 32767, 32767, -32768},
    '{1, 0, 0, 0, 0,   -10, -10,  10,  10,  0, 0,   0,   0,   0,   0},
    '{0, 0, 0, 0, 0,     0,   0,   0,   0,  1, 1,   0,   0,   0,   0},
    '{1, 400, 400, 200, 200, 300, 300, 300, 300, 1, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0,   300, 300, 500, 500,  0, 0,   0,   0,   0,   0},
    '{0, 0, 0, 0, 0,   500, 300, 300, 500,  0, 0,   0,   0,   0,   0},
    '{1, 32000, -32768, 32767, -32000, -32768, -32768, 32767, 32767,
        0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 32767, -32768, 32767, -32768, 1, 1, 32767, -32768, 32767, -32768}
  };

  function automatic longint to_fix(coord_t v);
    return longint'(v) <<< FRAC;
  endfunction

  function automatic coord_t to_int(longint q);
    longint ip;
    if (q < 0) begin
      ip = -((-q) >>> FRAC);
    end else begin
      ip = q >>> FRAC;
    end
    return ip[15:0];
  endfunction

  function automatic lcrw_pkg::outcode_t region_of(longint x, longint y);
    lcrw_pkg::outcode_t c;
    c = lcrw_pkg::CODE_INSIDE;
    if (x < to_fix(win_l)) begin
      c |= lcrw_pkg::CODE_LEFT;
    end else if (x > to_fix(win_r)) begin
      c |= lcrw_pkg::CODE_RIGHT;
    end
    if (y < to_fix(win_b)) begin
      c |= lcrw_pkg::CODE_BOTTOM;
    end else if (y > to_fix(win_t)) begin
      c |= lcrw_pkg::CODE_TOP;
    end
    return c;
  endfunction

  // Truncating a * b / d with the product kept exact and the quotient
  // magnitude saturated.
  function automatic longint scaled_quotient(longint a, longint b, longint d);
    logic [63:0]  ua, ub, ud;
    logic [127:0] prod, quo;
    bit           neg;
    neg = ((a < 0) != (b < 0)) != (d < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    ud = (d < 0) ? -d : d;
    if (ud == 64'd0) return 0;
    prod = {64'd0, ua} * {64'd0, ub};
    if (prod[127:64] >= ud) begin
      quo = QUO_SAT;
    end else begin
      quo = prod / {64'd0, ud};
    end
    if (quo > QUO_SAT) quo = QUO_SAT;
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic clip_t clip_segment(seg_t s);
    longint             x1, y1, x2, y2, nx, ny;
    lcrw_pkg::outcode_t c1, c2, co;
    bit                 ok;
    clip_t              r;
    x1 = to_fix(s.sx);
    y1 = to_fix(s.sy);
    x2 = to_fix(s.ex);
    y2 = to_fix(s.ey);
    c1 = region_of(x1, y1);
    c2 = region_of(x2, y2);
    ok = 1'b0;
    for (int rnd = 0; rnd <= int'(lcrw_pkg::MAX_ROUNDS); rnd++) begin
      if (c1 == lcrw_pkg::CODE_INSIDE && c2 == lcrw_pkg::CODE_INSIDE) begin
        ok = 1'b1;
        break;
      end
      if ((c1 & c2) != lcrw_pkg::CODE_INSIDE || rnd == int'(lcrw_pkg::MAX_ROUNDS)) break;
      co = (c1 != lcrw_pkg::CODE_INSIDE) ? c1 : c2;
      if ((co & lcrw_pkg::CODE_TOP) != lcrw_pkg::CODE_INSIDE) begin
        ny = to_fix(win_t);
        nx = x1 + scaled_quotient(x2 - x1, ny - y1, y2 - y1);
      end else if ((co & lcrw_pkg::CODE_BOTTOM) != lcrw_pkg::CODE_INSIDE) begin
        ny = to_fix(win_b);
        nx = x1 + scaled_quotient(x2 - x1, ny - y1, y2 - y1);
      end else if ((co & lcrw_pkg::CODE_RIGHT) != lcrw_pkg::CODE_INSIDE) begin
        nx = to_fix(win_r);
        ny = y1 + scaled_quotient(y2 - y1, nx - x1, x2 - x1);
      end else begin
        nx = to_fix(win_l);
        ny = y1 + scaled_quotient(y2 - y1, nx - x1, x2 - x1);
      end
      if (c1 != lcrw_pkg::CODE_INSIDE) begin
        x1 = nx;
        y1 = ny;
        c1 = region_of(x1, y1);
      end else begin
        x2 = nx;
        y2 = ny;
        c2 = region_of(x2, y2);
      end
    end
    r.acc = ok;
    r.csx = ok ? to_int(x1) : coord_t'(0);
    r.csy = ok ? to_int(y1) : coord_t'(0);
    r.cex = ok ? to_int(x2) : coord_t'(0);
    r.cey = ok ? to_int(y2) : coord_t'(0);
    return r;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int near_coord(int lo, int hi);
    int span, a, b;
    span = $urandom_range(0, 400);
    a = lo - span;
    b = hi + span;
    if (a < -32768) a = -32768;
    if (b > 32767) b = 32767;
    return a + int'($urandom_range(0, b - a));
  endfunction

  function automatic seg_t random_segment();
    int   xl, xh, yl, yh, mode;
    seg_t s;
    xl = (win_l < win_r) ? win_l : win_r;
    xh = (win_l < win_r) ? win_r : win_l;
    yl = (win_b < win_t) ? win_b : win_t;
    yh = (win_b < win_t) ? win_t : win_b;
    mode = $urandom_range(0, 7);
    if (mode == 0) begin
      s.sx = 16'(rand_coord());
      s.sy = 16'(rand_coord());
      s.ex = 16'(rand_coord());
      s.ey = 16'(rand_coord());
    end else begin
      s.sx = 16'(near_coord(xl, xh));
      s.sy = 16'(near_coord(yl, yh));
      s.ex = 16'(near_coord(xl, xh));
      s.ey = 16'(near_coord(yl, yh));
      if (mode == 1) s.ey = s.sy;
      if (mode == 2) s.ex = s.sx;
    end
    return s;
  endfunction

  task automatic note_mismatch(string field, longint got, longint want);
    mismatch_count++;
    $display("clip check failed at %0t: %s got %0d, want %0d", $realtime, field, got, want);
  endtask

  task automatic check_clip();
    clip_t want;
    if (pending_clips.size() == 0) begin
      note_mismatch("result with no segment pending, accepted", clip_link.accepted, 0);
      return;
    end
    want = pending_clips.pop_front();
    if (clip_link.accepted !== want.acc)
      note_mismatch("accepted", clip_link.accepted, want.acc);
    if (clip_link.clip_start_x !== want.csx)
      note_mismatch("clip_start_x", clip_link.clip_start_x, want.csx);
    if (clip_link.clip_start_y !== want.csy)
      note_mismatch("clip_start_y", clip_link.clip_start_y, want.csy);
    if (clip_link.clip_end_x !== want.cex)
      note_mismatch("clip_end_x", clip_link.clip_end_x, want.cex);
    if (clip_link.clip_end_y !== want.cey)
      note_mismatch("clip_end_y", clip_link.clip_end_y, want.cey);
  endtask

  task automatic put_segment(seg_t s, clip_t want);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      seg_link.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    seg_link.valid   <= 1'b1;
    seg_link.start_x <= s.sx;
    seg_link.start_y <= s.sy;
    seg_link.end_x   <= s.ex;
    seg_link.end_y   <= s.ey;
    do @(posedge clk_i); while (!seg_link.ready);
    pending_clips.push_back(want);
  endtask

  task automatic wait_idle();
    seg_link.valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_window(int l, int b, int r, int t);
    int                 vals[4];
    lcrw_pkg::reg_idx_t ids[4];
    vals = '{l, b, r, t};
    ids  = '{lcrw_pkg::REG_WINDOW_LEFT, lcrw_pkg::REG_WINDOW_BOTTOM,
             lcrw_pkg::REG_WINDOW_RIGHT, lcrw_pkg::REG_WINDOW_TOP};
    for (int k = 0; k < 4; k++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= ids[k];
      cfg_data_i <= 16'(vals[k]);
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    win_l = 16'(l);
    win_b = 16'(b);
    win_r = 16'(r);
    win_t = 16'(t);
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && clip_link.valid && clip_link.ready) check_clip();
      if (stall_left > 0) begin
        stall_left--;
        clip_link.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        clip_link.ready <= 1'b0;
      end else begin
        clip_link.ready <= 1'b1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("line_clipper_rect_window: mismatch");
    $finish;
  end

  initial begin
    seg_t  s;
    clip_t want;
    int    a, b, c, d;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_idx_i        = lcrw_pkg::REG_WINDOW_LEFT;
    cfg_data_i       = '0;
    seg_link.valid   = 1'b0;
    seg_link.start_x = '0;
    seg_link.start_y = '0;
    seg_link.end_x   = '0;
    seg_link.end_y   = '0;
    clip_link.ready  = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (probes[i]) begin
      if (probes[i].win) begin
        wait_idle();
        write_window(probes[i].wl, probes[i].wb, probes[i].wr, probes[i].wt);
      end
      s.sx = 16'(probes[i].sx);
      s.sy = 16'(probes[i].sy);
      s.ex = 16'(probes[i].ex);
      s.ey = 16'(probes[i].ey);
      if (probes[i].typed) begin
        want.acc = probes[i].acc;
        want.csx = 16'(probes[i].csx);
        want.csy = 16'(probes[i].csy);
        want.cex = 16'(probes[i].cex);
        want.cey = 16'(probes[i].cey);
      end else begin
        want = clip_segment(s);
      end
      put_segment(s, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      a = rand_coord();
      b = rand_coord();
      c = rand_coord();
      d = rand_coord();
      wait_idle();
      idle_on = (p != 3 && p != PHASES - 1);
      case (p)
        1: begin
          write_window(a < b ? a : b, c < d ? c : d, a < b ? b : a, c < d ? d : c);
        end
        2: begin
          write_window(a < b ? b : a, c < d ? d : c, a < b ? a : b, c < d ? c : d);
        end
        3: begin
          write_window(-32768, -32768, 32767, 32767);
        end
        4: begin
          write_window(a, c, a, c);
        end
        5: begin
          a = a / 2;
          c = c / 2;
          write_window(a, c, a + $urandom_range(0, 50), c + $urandom_range(0, 50));
        end
        6: begin
          write_window(a, b, c, d);
        end
        default: begin
          write_window(lcrw_pkg::WINDOW_LEFT_RST, lcrw_pkg::WINDOW_BOTTOM_RST,
                       lcrw_pkg::WINDOW_RIGHT_RST, lcrw_pkg::WINDOW_TOP_RST);
        end
      endcase
      repeat (PER_PHASE) begin
        s = random_segment();
        put_segment(s, clip_segment(s));
      end
    end

    seg_link.valid <= 1'b0;
    while (pending_clips.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("line_clipper_rect_window: match");
    end else begin
      $display("line_clipper_rect_window: mismatch");
    end
    $finish;
  end

endmodule
